[rtl/mse_pkg.sv]
// Shared types for the merge sort engine: beat structs and cell link types.
`default_nettype none

package mse_pkg;

  localparam int unsigned DataW = 32;

  // Input beat: one element of the run.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_beat_t;

  // Result beat: one element of the sorted run.
  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    final_res;
    logic                    overflowed;
  } out_beat_t;

  // Contents of one cell, as seen by its neighbors.
  typedef struct packed {
    logic                    vld;
    logic signed [DataW-1:0] val;
  } slot_t;

  // Row-wide command to every cell.
  typedef struct packed {
    logic load;
    logic drain;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/merge_sort_engine_unit.sv]
// Top level of the merge sort engine: a row of sorting cells and its control.
`default_nettype none

// Usage
//   Input channel: a beat (in_i.value, in_i.last) is taken at a rising edge
//   where start_i is high and busy_o is low. in_i.last closes the run.
//   Each beat drops into its ordered place in a row of MAX_ITEMS cells in
//   the cycle it is taken. Result channel: res_strobe_o marks a result
//   beat for exactly one cycle; it cannot be held off. The burst starts
//   the cycle after the closing beat and delivers the n stored elements
//   in ascending order on consecutive cycles, draining the row toward
//   cell 0. res_o.final_res marks the last. busy_o is high for the whole
//   burst.
//   Capacity: beats that arrive while all MAX_ITEMS cells hold data are
//   dropped, and every result of that run carries res_o.overflowed.
//   Reset (rst_ni low, asynchronous) empties every cell, clears the
//   overflow flag and returns the block to loading.

module merge_sort_engine_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire mse_pkg::in_beat_t  in_i,
  output logic                    res_strobe_o,
  output mse_pkg::out_beat_t      res_o
);

  localparam logic StLoad = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;
  logic drop_q, drop_d;
  logic accept;
  logic full;

  mse_pkg::cell_ctrl_t ctrl;
  mse_pkg::slot_t      slot [MAX_ITEMS];
  logic                ins  [MAX_ITEMS];

  assign busy_o = (state_q == StEmit);
  assign accept = start_i && !busy_o;
  // Last cell in use means the row is full.
  assign full   = slot[MAX_ITEMS-1].vld;

  // Insert only when there is room; drain one cell per result cycle.
  assign ctrl.load  = accept && !full;
  assign ctrl.drain = busy_o;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    mse_pkg::slot_t left_slot, right_slot;
    logic           left_ins;

    if (i == 0) begin : g_head
      assign left_slot = '0;
      assign left_ins  = 1'b0;
    end else begin : g_body
      assign left_slot = slot[i-1];
      assign left_ins  = ins[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_mid
      assign right_slot = slot[i+1];
    end

    mse_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .din_i      (in_i.value),
      .left_i     (left_slot),
      .left_ins_i (left_ins),
      .right_i    (right_slot),
      .slot_o     (slot[i]),
      .ins_o      (ins[i])
    );
  end

  // Cell 0 always holds the smallest remaining element.
  assign res_strobe_o       = busy_o;
  assign res_o.sorted_value = slot[0].val;
  assign res_o.final_res    = !slot[1].vld;
  assign res_o.overflowed   = drop_q;

  always_comb begin
    state_d = state_q;
    drop_d  = drop_q;
    case (state_q)
      StLoad: begin
        if (accept) begin
          drop_d = drop_q | full;
          if (in_i.last) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        // Leave the burst and clear the run after its last beat.
        if (res_o.final_res) begin
          state_d = StLoad;
          drop_d  = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

endmodule

`default_nettype wire

[rtl/mse_cell.sv]
// One cell of the sorting row: holds one element; inserts or shifts on load or drain.
`default_nettype none

module mse_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mse_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic signed [mse_pkg::DataW-1:0] din_i,
  input  wire mse_pkg::slot_t                 left_i,
  input  wire logic                           left_ins_i,
  input  wire mse_pkg::slot_t                 right_i,
  output mse_pkg::slot_t                      slot_o,
  output logic                                ins_o
);

  logic                           vld_q, vld_d;
  logic signed [mse_pkg::DataW-1:0] val_q, val_d;

  // New element belongs at or before this cell.
  assign ins_o = !vld_q || (din_i < val_q);

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctrl_i.load) begin
      if (left_ins_i) begin
        vld_d = left_i.vld;
        val_d = left_i.val;
      end else if (ins_o) begin
        vld_d = 1'b1;
        val_d = din_i;
      end
    end else if (ctrl_i.drain) begin
      vld_d = right_i.vld;
      val_d = right_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign slot_o.vld = vld_q;
  assign slot_o.val = val_q;

endmodule

`default_nettype wire

[rtl/mse_checker.sv]
// Port-level checks for the merge sort engine, bound to its top level.
`default_nettype none

module mse_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire mse_pkg::in_beat_t  in_i,
  input wire logic               res_strobe_o,
  input wire mse_pkg::out_beat_t res_o
);

  // A closing beat starts the burst in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && in_i.last |=> busy_o && res_strobe_o)
    else $error("burst did not follow closing beat");

  // While busy, a result beat is shown every cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> res_strobe_o)
    else $error("busy without result beat");

  // Results of a burst come out in ascending order without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.final_res |=>
      res_strobe_o && (res_o.sorted_value >= $signed($past(res_o.sorted_value))))
    else $error("burst out of order or broken");

  // Overflow flag holds across a burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.final_res |=> res_o.overflowed == $past(res_o.overflowed))
    else $error("overflow flag changed within burst");

  // The block is free again right after the final beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.final_res |=> !busy_o)
    else $error("still busy after final beat");

endmodule

bind merge_sort_engine_unit mse_checker u_mse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .in_i         (in_i),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);

`default_nettype wire

[bench/tb_top.sv]
// Testbench for merge_sort_engine_unit: directed table, random runs, sorted-run checking.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned RandItems  = 210;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DirRows    = 20;

  // One row of the directed table. Where typed is set, the row closes a
  // one-element run, so its single result is written in by hand.
  typedef struct packed {
    logic signed [mse_pkg::DataW-1:0] value;
    logic                             last;
    logic                             typed;
    logic signed [mse_pkg::DataW-1:0] want;
  } dir_row_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start_i = 1'b0;
  mse_pkg::in_beat_t  in_i    = '0;
  logic               busy_o;
  logic               res_strobe_o;
  mse_pkg::out_beat_t res_o;

  // Predictor state: the open run as the block should hold it.
  logic signed [mse_pkg::DataW-1:0] run_store [Capacity];
  int unsigned                      run_len     = 0;
  logic                             run_dropped = 1'b0;

  mse_pkg::out_beat_t burst_q [$];   // results of the last beat fed to the predictor
  mse_pkg::out_beat_t sorted_due [$]; // results still owed by the block, oldest first
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned idle_pct       = 0;
  dir_row_t    dir_rows [DirRows];

  merge_sort_engine_unit #(
    .MAX_ITEMS(Capacity)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Store one beat of the open run, or drop it if the store is full; on the closing
  // beat, sort the stored elements ascending, emit them as a burst and clear the run.
  function automatic void absorb_beat(mse_pkg::in_beat_t b);
    logic signed [mse_pkg::DataW-1:0] ordered [Capacity];
    logic signed [mse_pkg::DataW-1:0] key;
    int                               j;
    mse_pkg::out_beat_t               r;
    burst_q.delete();
    if (run_len < Capacity) begin
      run_store[run_len] = b.value;
      run_len++;
    end else begin
      // Full store: drop the beat but remember it for the overflow flag.
      run_dropped = 1'b1;
    end
    if (b.last) begin
      for (int i = 0; i < run_len; i++) ordered[i] = run_store[i];
      for (int i = 1; i < run_len; i++) begin
        key = ordered[i];
        j   = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j+1] = ordered[j];
          j--;
        end
        ordered[j+1] = key;
      end
      for (int i = 0; i < run_len; i++) begin
        r.sorted_value = ordered[i];
        r.final_res    = (i == run_len - 1);
        r.overflowed   = run_dropped;
        burst_q = {burst_q, r};
      end
      run_len     = 0;
      run_dropped = 1'b0;
    end
  endfunction

  // Values: full random, a narrow band around zero so ties are common, and
  // the neighborhood of both extremes.
  function automatic logic signed [mse_pkg::DataW-1:0] pick_value();
    logic [mse_pkg::DataW-1:0] v;
    case ($urandom_range(3))
      0, 1: v = $urandom;
      2:    v = $urandom_range(8) - 4;
      default: begin
        if ($urandom_range(1) == 1) v = 32'h7FFF_FFFF - $urandom_range(2);
        else                        v = 32'h8000_0000 + $urandom_range(2);
      end
    endcase
    return $signed(v);
  endfunction

  // Drive one beat after a random idle gap; hold it until the block takes it.
  task automatic send_beat(mse_pkg::in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    in_i    <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk_i);
  endtask

  // Result checker and activity counter for the watchdog. Results are
  // sampled at the rising edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles = 0;
    end else begin
      if ((start_i && !busy_o) || res_strobe_o) stall_cycles = 0;
      else                                      stall_cycles++;
      if (res_strobe_o) begin
        if (sorted_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: value %0d final %0b ovf %0b",
                     res_o.sorted_value, res_o.final_res, res_o.overflowed);
        end else begin
          if (res_o.sorted_value !== sorted_due[0].sorted_value ||
              res_o.final_res    !== sorted_due[0].final_res ||
              res_o.overflowed   !== sorted_due[0].overflowed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: want value %0d final %0b ovf %0b, got %0d %0b %0b",
                       sorted_due[0].sorted_value, sorted_due[0].final_res,
                       sorted_due[0].overflowed, res_o.sorted_value,
                       res_o.final_res, res_o.overflowed);
          end
          void'(sorted_due.pop_front());
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("merge_sort_engine_unit test failed");
    $finish;
  end

  initial begin
    mse_pkg::in_beat_t  b;
    mse_pkg::out_beat_t want;
    int unsigned run_idx;
    int unsigned sent;
    int unsigned run_size;
    int unsigned pct_by_phase [4];

    // Single-element runs at both extremes, zero and -1, then runs with ties,
    // both extremes mixed in, reverse order, alternating bit patterns and a pair.
    dir_rows = '{
      '{32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF},
      '{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
      '{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000},
      '{32'shFFFF_FFFF, 1'b1, 1'b1, 32'shFFFF_FFFF},
      '{32'sd3,         1'b0, 1'b0, 32'sd0},
      '{-32'sd5,        1'b0, 1'b0, 32'sd0},
      '{32'sh7FFF_FFFF, 1'b0, 1'b0, 32'sd0},
      '{32'sh8000_0000, 1'b0, 1'b0, 32'sd0},
      '{32'sd3,         1'b1, 1'b0, 32'sd0},
      '{32'sd10,        1'b0, 1'b0, 32'sd0},
      '{32'sd0,         1'b0, 1'b0, 32'sd0},
      '{-32'sd10,       1'b1, 1'b0, 32'sd0},
      '{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0},
      '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
      '{32'sd1,         1'b0, 1'b0, 32'sd0},
      '{-32'sd1,        1'b0, 1'b0, 32'sd0},
      '{32'sh8000_0001, 1'b0, 1'b0, 32'sd0},
      '{32'sh7FFF_FFFE, 1'b1, 1'b0, 32'sd0},
      '{32'sd2,         1'b0, 1'b0, 32'sd0},
      '{32'sd2,         1'b1, 1'b0, 32'sd0}
    };
    // Sender idle share per phase. The receiver cannot stall, so its
    // phase runs like the no-idle one.
    pct_by_phase = '{0, 78, 0, 30};

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, no idling.
    for (int i = 0; i < DirRows; i++) begin
      b.value = dir_rows[i].value;
      b.last  = dir_rows[i].last;
      send_beat(b);
      absorb_beat(b);
      if (dir_rows[i].typed) begin
        want.sorted_value = dir_rows[i].want;
        want.final_res    = 1'b1;
        want.overflowed   = 1'b0;
        sorted_due = {sorted_due, want};
      end else begin
        sorted_due = {sorted_due, burst_q};
      end
    end
    wait_drained();

    // Random runs. The first fills the store exactly; the second is one
    // beat too long, so its closing beat is the dropped one. After that
    // mostly short runs, now and then one around capacity.
    run_idx = 0;
    sent    = 0;
    while (sent < RandItems) begin
      idle_pct = pct_by_phase[(run_idx / 4) % 4];
      if (run_idx == 0)                  run_size = Capacity;
      else if (run_idx == 1)             run_size = Capacity + 1;
      else if ($urandom_range(24) == 0)  run_size = $urandom_range(Capacity + 3, Capacity - 2);
      else                               run_size = $urandom_range(12, 1);
      for (int i = 0; i < run_size; i++) begin
        b.value = pick_value();
        b.last  = (i == run_size - 1);
        send_beat(b);
        absorb_beat(b);
        sorted_due = {sorted_due, burst_q};
      end
      sent += run_size;
      run_idx++;
      // Now and then let the whole burst drain before the next run.
      if ($urandom_range(9) == 0) wait_drained();
    end

    wait_drained();
    // Catch stray result beats after the last burst.
    repeat (3 * Capacity) @(posedge clk_i);
    if (sorted_due.size() != 0) begin
      $display("results never delivered: %0d", sorted_due.size());
      mismatch_count += sorted_due.size();
    end
    if (mismatch_count == 0) $display("merge_sort_engine_unit test passed");
    else                     $display("merge_sort_engine_unit test failed");
    $finish;
  end

endmodule
